### rtl/cdq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types, codes and defaults for the circular deque unit.
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int CAP_RESET      = 16;

	localparam int CAP_W    = 5;
	localparam int FUNC_W   = 2;
	localparam int STATUS_W = 2;

	localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_PUSH_REAR  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 2'd2;
	localparam logic [FUNC_W-1:0] FN_POP_REAR   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// broadcast to every cell of the row
	typedef struct packed {
		logic clear;
		logic push_front;
		logic push_rear;
		logic pop_front;
		logic pop_rear;
	} cell_ctrl_t;

endpackage
`default_nettype wire

### rtl/cdq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_cell
// One entry of the deque row: a word and a valid bit that move to or from
// the neighbors on front operations, or load/drop locally at the rear end.
// ----------------------------------------------------------------------------
module cdq_cell #(
	parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire cdq_pkg::cell_ctrl_t ctrl,
	input  wire                    left_vld,
	input  wire [DATA_WIDTH-1:0]   left_word,
	input  wire                    right_vld,
	input  wire [DATA_WIDTH-1:0]   right_word,
	input  wire [DATA_WIDTH-1:0]   push_word,
	output logic                   vld,
	output logic [DATA_WIDTH-1:0]  word,
	output logic [DATA_WIDTH-1:0]  rear_word
);

	logic                  vld_q;
	logic [DATA_WIDTH-1:0] word_q;
	logic                  is_tail;
	logic                  is_gap;

	// rear entry: valid with nothing valid behind it
	assign is_tail = vld_q & ~right_vld;
	// first free slot behind the rear
	assign is_gap  = ~vld_q & left_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.clear) begin
			vld_q <= 1'b0;
		end else if (ctrl.push_front) begin
			vld_q <= left_vld;
		end else if (ctrl.pop_front) begin
			vld_q <= right_vld;
		end else if (ctrl.push_rear && is_gap) begin
			vld_q <= 1'b1;
		end else if (ctrl.pop_rear && is_tail) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push_front) begin
			word_q <= left_word;
		end else if (ctrl.pop_front) begin
			word_q <= right_word;
		end else if (ctrl.push_rear && is_gap) begin
			word_q <= push_word;
		end
	end

	assign vld       = vld_q;
	assign word      = word_q;
	assign rear_word = word_q & {DATA_WIDTH{is_tail}};

endmodule
`default_nettype wire

### rtl/circular_deque_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque_unit
// Double-ended queue kept in a row of cells; front at cell 0.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   tvalid/tready      tuser: func, tdata: value
//  m_*      out  tvalid/tready      tuser: status, now_empty, now_full;
//                                   tdata: popped_value
//  cfg_*    in   cfg_we             cfg_data: capacity
//
// One word per cycle: every operation is a single update of the cell row.
// The result sits in an output register; a new word is taken while it waits
// as long as m_tready is high in the same cycle.
// Reset and a capacity write clear every cell's valid bit.
// ----------------------------------------------------------------------------
module circular_deque_unit #(
	parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire [((DATA_WIDTH+7)/8)*8-1:0]   s_tdata,  // value
	input  wire [cdq_pkg::FUNC_W-1:0]        s_tuser,  // func
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [((DATA_WIDTH+7)/8)*8-1:0]  m_tdata,  // popped_value
	output logic [cdq_pkg::STATUS_W+1:0]     m_tuser,  // status, now_empty, now_full
	input  wire                              cfg_we,
	input  wire [cdq_pkg::CAP_W-1:0]         cfg_data
);

	localparam int TDATA_W   = ((DATA_WIDTH + 7) / 8) * 8;
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int CAP_RST   = (cdq_pkg::CAP_RESET > DEPTH) ? DEPTH : cdq_pkg::CAP_RESET;

	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       cap_q;
	logic [CNT_W-1:0]       count_nxt;
	logic [31:0]            cfg_ext;
	logic [CNT_W-1:0]       cap_nxt;

	logic [cdq_pkg::FUNC_W-1:0]   func;
	logic [DATA_WIDTH-1:0]        push_word;
	logic                         in_acc;
	logic                         is_push;
	logic                         is_full;
	logic                         is_empty;
	logic [cdq_pkg::STATUS_W-1:0] status;
	logic                         op_ok;
	logic [DATA_WIDTH-1:0]        popped;
	logic [DATA_WIDTH-1:0]        rear_sel;

	cdq_pkg::cell_ctrl_t    ctrl;
	logic [DEPTH-1:0]       cell_vld;
	logic [DATA_WIDTH-1:0]  cell_word [DEPTH];
	logic [DATA_WIDTH-1:0]  cell_rear [DEPTH];

	logic                         m_valid_q;
	logic [DATA_WIDTH-1:0]        m_popped_q;
	logic [cdq_pkg::STATUS_W-1:0] m_status_q;
	logic                         m_empty_q;
	logic                         m_full_q;

	assign func      = s_tuser;
	assign push_word = s_tdata[DATA_WIDTH-1:0];
	assign s_tready  = ~m_valid_q | m_tready;
	assign in_acc    = s_tvalid & s_tready;

	assign is_push  = (func == cdq_pkg::FN_PUSH_FRONT) || (func == cdq_pkg::FN_PUSH_REAR);
	assign is_full  = (count_q == cap_q);
	assign is_empty = (count_q == '0);

	always_comb begin
		if (is_push && is_full) begin
			status = cdq_pkg::ST_FULL;
		end else if (!is_push && is_empty) begin
			status = cdq_pkg::ST_EMPTY;
		end else begin
			status = cdq_pkg::ST_DONE;
		end
	end
	assign op_ok = in_acc & (status == cdq_pkg::ST_DONE);

	always_comb begin
		ctrl.clear      = cfg_we;
		ctrl.push_front = op_ok & (func == cdq_pkg::FN_PUSH_FRONT);
		ctrl.push_rear  = op_ok & (func == cdq_pkg::FN_PUSH_REAR);
		ctrl.pop_front  = op_ok & (func == cdq_pkg::FN_POP_FRONT);
		ctrl.pop_rear   = op_ok & (func == cdq_pkg::FN_POP_REAR);
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic                  lv;
			logic [DATA_WIDTH-1:0] lw;
			logic                  rv;
			logic [DATA_WIDTH-1:0] rw;
			if (gi == 0) begin : g_first
				assign lv = 1'b1;
				assign lw = push_word;
			end else begin : g_mid_l
				assign lv = cell_vld[gi-1];
				assign lw = cell_word[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign rv = 1'b0;
				assign rw = '0;
			end else begin : g_mid_r
				assign rv = cell_vld[gi+1];
				assign rw = cell_word[gi+1];
			end
			cdq_cell #(
				.DATA_WIDTH (DATA_WIDTH)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.left_vld   (lv),
				.left_word  (lw),
				.right_vld  (rv),
				.right_word (rw),
				.push_word  (push_word),
				.vld        (cell_vld[gi]),
				.word       (cell_word[gi]),
				.rear_word  (cell_rear[gi])
			);
		end
	endgenerate

	// at most one cell flags itself as the rear
	always_comb begin
		rear_sel = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_sel = rear_sel | cell_rear[i];
		end
	end

	always_comb begin
		popped = '0;
		if (ctrl.pop_front) begin
			popped = cell_word[0];
		end else if (ctrl.pop_rear) begin
			popped = rear_sel;
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (ctrl.push_front || ctrl.push_rear) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctrl.pop_front || ctrl.pop_rear) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	// saturate capacity into 1..DEPTH
	always_comb begin
		cfg_ext = 32'(cfg_data);
		if (cfg_ext == 32'd0) begin
			cap_nxt = CNT_W'(1);
		end else if (cfg_ext > 32'(DEPTH)) begin
			cap_nxt = CNT_W'(DEPTH);
		end else begin
			cap_nxt = cfg_ext[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CNT_W'(CAP_RST);
		end else if (cfg_we) begin
			count_q <= '0;
			cap_q   <= cap_nxt;
		end else begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (in_acc) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			m_popped_q <= popped;
			m_status_q <= status;
			m_empty_q  <= (count_nxt == '0);
			m_full_q   <= (count_nxt == cap_q);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = TDATA_W'(m_popped_q);
	assign m_tuser  = {m_full_q, m_empty_q, m_status_q};

`ifndef SYNTHESIS
	a_count_cap : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_q)
		else $error("entry count above capacity");

	a_vld_count : assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_vld) == int'(count_q))
		else $error("cell valid bits disagree with entry count");

	a_front_vld : assert property (@(posedge clk) disable iff (!arst_n)
		cell_vld[0] == (count_q != '0))
		else $error("front cell valid disagrees with empty flag");

	a_refused_zero : assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && (m_status_q != cdq_pkg::ST_DONE) |-> (m_popped_q == '0))
		else $error("refused operation returned a nonzero word");
`endif

endmodule
`default_nettype wire
